// ===== sv/cfcl_pkg.sv =====
// shared constants, codes and crc step function for the framed command link
package cfcl_pkg;

  localparam int unsigned ReplyBytes = 11;
  localparam int unsigned FrameBytes = 10;
  localparam int unsigned CntW       = 4;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] StartByte = 8'd2;
  localparam logic [7:0] LenByte   = 8'd5;
  localparam logic [7:0] StopByte  = 8'd3;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RX   = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_CRC_SEED = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_REPLY_ID = 1'b1;

  localparam logic OUT_TX      = 1'b0;
  localparam logic OUT_VERDICT = 1'b1;

  // one byte through crc-16, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/crc_framed_command_link.sv =====
// framed command link: frame sender, reply collector and reply checker
//
// Usage: one request channel (in_valid_i/in_ready_o) carries a request type.
// A send request emits ten frame bytes on the result channel
// (out_valid_o/out_ready_i), one per cycle while the receiver takes them,
// the tenth flagged by frame_last_o.
// A received-byte request is stored and gives no result; bytes
// past the eleventh are dropped and mark the reply as too long.
// An end-of-window request scans the eleven stored bytes one per cycle
// through the shared crc byte unit and then emits one verdict; with a wrong
// byte count the scan is skipped and the verdict follows directly.
// The crc byte unit is the one datapath used by both sender and checker,
// and it sets the rate: one byte per cycle, unless the receiver stalls a send.
// A new request is taken only once the previous one is finished, so when
// the receiver stalls, the current result holds and in_ready_o stays low.
// Registers must be written by the user only while idle, which the block
// does not enforce, on the always-ready configuration channel (index 0 crc
// seed, index 1 expected reply id). Reset clears sequencer, byte count and
// registers (seed 0, reply id 50); stored bytes are undefined until written.
module crc_framed_command_link (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [7:0]                        packet_id_i,
  input  logic signed [31:0]                cmd_value_i,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_kind_o,
  output logic [7:0]                        tx_byte_o,
  output logic                              frame_last_o,
  output logic                              reply_ok_o,
  output logic [7:0]                        fault_code_o,
  output logic                              fault_seen_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cfcl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cfcl_pkg::CfgDataW-1:0]     cfg_data_i
);
  import cfcl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_VERD = 2'd3;

  localparam logic [CntW-1:0] LastFrameIdx = CntW'(FrameBytes - 1);
  localparam logic [CntW-1:0] LastReplyIdx = CntW'(ReplyBytes - 1);
  localparam logic [CntW-1:0] ReplyFull    = CntW'(ReplyBytes);
  localparam logic [CntW-1:0] ReplyOver    = CntW'(ReplyBytes + 1);

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] reply_count_q, reply_count_d;
  logic [15:0]     crc_q, crc_d;
  logic            ok_q, ok_d;
  logic [7:0]      fault_q, fault_d;
  logic [15:0]     crc_seed_q;
  logic [7:0]      reply_id_q;
  logic [7:0]      id_q;
  logic [31:0]     value_q;
  logic [7:0]      reply_store_q [ReplyBytes];

  logic            in_acc, out_acc;
  logic [7:0]      unit_byte;
  logic [15:0]     unit_crc;
  logic [7:0]      frame_byte;
  logic [7:0]      scan_byte;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == ST_SEND) || (state_q == ST_VERD);
  assign out_acc     = out_valid_o & out_ready_i;
  assign scan_byte   = reply_store_q[idx_q];

  // frame byte for the current index
  always_comb begin
    case (idx_q)
      4'd0:    frame_byte = StartByte;
      4'd1:    frame_byte = LenByte;
      4'd2:    frame_byte = id_q;
      4'd3:    frame_byte = value_q[31:24];
      4'd4:    frame_byte = value_q[23:16];
      4'd5:    frame_byte = value_q[15:8];
      4'd6:    frame_byte = value_q[7:0];
      4'd7:    frame_byte = crc_q[15:8];
      4'd8:    frame_byte = crc_q[7:0];
      default: frame_byte = StopByte;
    endcase
  end

  // shared crc byte unit
  assign unit_byte = (state_q == ST_SCAN) ? scan_byte : frame_byte;
  assign unit_crc  = crc_byte(crc_q, unit_byte);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    reply_count_d = reply_count_q;
    crc_d         = crc_q;
    ok_d          = ok_q;
    fault_d       = fault_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_SEND: begin
              state_d = ST_SEND;
              idx_d   = '0;
              crc_d   = crc_seed_q;
            end
            REQ_RX: begin
              if (reply_count_q < ReplyFull) begin
                reply_count_d = reply_count_q + 1'b1;
              end else begin
                reply_count_d = ReplyOver;
              end
            end
            REQ_END: begin
              ok_d          = (reply_count_q == ReplyFull);
              fault_d       = '0;
              idx_d         = '0;
              crc_d         = crc_seed_q;
              reply_count_d = '0;
              state_d       = (reply_count_q == ReplyFull) ? ST_SCAN : ST_VERD;
            end
            default: ;
          endcase
        end
      end
      ST_SEND: begin
        if (out_acc) begin
          if (idx_q >= 4'd2 && idx_q <= 4'd6) begin
            crc_d = unit_crc;
          end
          if (idx_q == LastFrameIdx) begin
            state_d = ST_IDLE;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN: begin
        case (idx_q)
          4'd0:    ok_d = ok_q & (scan_byte == StartByte);
          4'd2: begin
            ok_d  = ok_q & (scan_byte == reply_id_q);
            crc_d = unit_crc;
          end
          4'd7: begin
            fault_d = scan_byte;
            crc_d   = unit_crc;
          end
          4'd8:    ok_d = ok_q & (scan_byte == crc_q[15:8]);
          4'd9:    ok_d = ok_q & (scan_byte == crc_q[7:0]);
          4'd10:   ok_d = ok_q & (scan_byte == StopByte);
          default: begin
            if (idx_q >= 4'd3 && idx_q <= 4'd6) begin
              crc_d = unit_crc;
            end
          end
        endcase
        if (idx_q == LastReplyIdx) begin
          state_d = ST_VERD;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_VERD: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      reply_count_q <= '0;
      crc_q         <= '0;
      ok_q          <= 1'b0;
      fault_q       <= '0;
      crc_seed_q    <= '0;
      reply_id_q    <= 8'd50;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      reply_count_q <= reply_count_d;
      crc_q         <= crc_d;
      ok_q          <= ok_d;
      fault_q       <= fault_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CRC_SEED: crc_seed_q <= cfg_data_i;
          CFG_REPLY_ID: reply_id_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // request payload and reply store
  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == REQ_SEND) begin
      id_q    <= packet_id_i;
      value_q <= cmd_value_i;
    end
    if (in_acc && req_type_i == REQ_RX && reply_count_q < ReplyFull) begin
      reply_store_q[reply_count_q] <= rx_byte_i;
    end
  end

  assign out_kind_o   = (state_q == ST_VERD) ? OUT_VERDICT : OUT_TX;
  assign tx_byte_o    = (state_q == ST_SEND) ? frame_byte : 8'd0;
  assign frame_last_o = (state_q == ST_SEND) && (idx_q == LastFrameIdx);
  assign reply_ok_o   = (state_q == ST_VERD) && ok_q;
  assign fault_code_o = reply_ok_o ? fault_q : 8'd0;
  assign fault_seen_o = reply_ok_o && (fault_q != 8'd0);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a result is pending");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_count_q <= ReplyOver)
    else $error("reply count out of range");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && frame_last_o |=> in_ready_o)
    else $error("sequencer did not return to idle after last frame byte");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= LastReplyIdx))
    else $error("scan index past reply length");

  a_scan_to_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && (idx_q == LastReplyIdx) |=> (state_q == ST_VERD))
    else $error("scan did not end in a verdict");

endmodule
